FILE: hw/rtl/fprc_pkg.sv
// Shared types and field layout for the frustum point and rectangle cull block.
`timescale 1ns / 1ps

package fprc_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_POINT  = 2'd1,
        FUNC_CORNER = 2'd2
    } t_func;

    localparam int unsigned COEF_W    = 32;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned SUM_W     = 66;
    localparam int unsigned NUM_COEFS = 4;
    localparam int unsigned D_SHIFT   = 16;

    localparam int unsigned PSEL_W = 3;
    localparam int unsigned CSEL_W = 2;

    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 8;
    localparam int unsigned M_TUSER_W = 1;

    localparam int unsigned PSEL_LSB = 0;
    localparam int unsigned CSEL_LSB = PSEL_LSB + PSEL_W;
    localparam int unsigned COEF_LSB = CSEL_LSB + CSEL_W;
    localparam int unsigned X_LSB    = COEF_LSB + COEF_W;
    localparam int unsigned Y_LSB    = X_LSB + POS_W;
    localparam int unsigned Z_LSB    = Y_LSB + POS_W;

    localparam logic [1:0] COEF_A = 2'd0;
    localparam logic [1:0] COEF_B = 2'd1;
    localparam logic [1:0] COEF_C = 2'd2;
    localparam logic [1:0] COEF_D = 2'd3;

endpackage

FILE: hw/rtl/frustum_point_rect_cull.sv
// Six-plane view-frustum cull of points and rectangles given corner by corner.
//
// Input stream (i_s_*): tuser carries the function code; a load word writes
// one plane coefficient, a point word asks for one verdict, a corner word
// adds a rectangle corner and tlast marks the final corner of a rectangle.
// Output stream (o_m_*): one word per point and one per final corner; tdata
// bit 0 is the inside flag, tuser bit 0 is set for a rectangle verdict.
// Loads, unused codes and non-final corners give no output word.
// A verdict passes through the input register, the product register
// (three 32x32 multiplies and one shifted D term per plane), then the
// 66-bit sign test per plane into the result register.
// Throughput: one word per cycle; the pipeline accepts a new word every cycle
// while the result register is empty or being taken.
// When the receiver stalls, filled stages hold and bubbles close up, so
// o_s_tready drops only once all three stages hold words.
// Reset clears all plane coefficients to zero (every item is then culled),
// empties the pipeline and clears the rectangle corner notes.
`timescale 1ns / 1ps

module frustum_point_rect_cull #(
    parameter int unsigned NUM_PLANES = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // plane_sel, coef_sel, coef_value, pos_x, pos_y, pos_z, zero pad
    input  logic [fprc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func
    input  logic [fprc_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // inside_res, zero pad
    output logic [fprc_pkg::M_TDATA_W-1:0] o_m_tdata,
    // was_rectangle
    output logic [fprc_pkg::M_TUSER_W-1:0] o_m_tuser
);

    localparam logic [NUM_PLANES-1:0] FULL_MASK = '1;

    fprc_pkg::t_func                         s_func;
    logic [fprc_pkg::PSEL_W-1:0]             s_psel;
    logic [fprc_pkg::CSEL_W-1:0]             s_csel;
    logic signed [fprc_pkg::COEF_W-1:0]      s_coef;
    logic                                    s_accept;
    logic                                    s_test;

    logic signed [fprc_pkg::COEF_W-1:0]      r_coef [NUM_PLANES][fprc_pkg::NUM_COEFS];

    logic                                    r1_valid;
    logic                                    r1_rect;
    logic                                    r1_last;
    logic signed [fprc_pkg::POS_W-1:0]       r1_x;
    logic signed [fprc_pkg::POS_W-1:0]       r1_y;
    logic signed [fprc_pkg::POS_W-1:0]       r1_z;

    logic                                    r2_valid;
    logic                                    r2_rect;
    logic                                    r2_last;
    logic signed [fprc_pkg::PROD_W-1:0]      r2_prod [NUM_PLANES][fprc_pkg::NUM_COEFS];
    logic signed [fprc_pkg::PROD_W-1:0]      n_prod  [NUM_PLANES][fprc_pkg::NUM_COEFS];

    logic                                    r_o_valid;
    logic                                    r_o_inside;
    logic                                    r_o_rect;
    logic [NUM_PLANES-1:0]                   r_seen;
    logic [NUM_PLANES-1:0]                   n_seen;
    logic [NUM_PLANES-1:0]                   ahead;
    logic signed [fprc_pkg::SUM_W-1:0]       plane_sum [NUM_PLANES];

    logic                                    rdy1;
    logic                                    rdy2;
    logic                                    rdy3;

    assign s_func = fprc_pkg::t_func'(i_s_tuser);
    assign s_psel = i_s_tdata[fprc_pkg::PSEL_LSB +: fprc_pkg::PSEL_W];
    assign s_csel = i_s_tdata[fprc_pkg::CSEL_LSB +: fprc_pkg::CSEL_W];
    assign s_coef = i_s_tdata[fprc_pkg::COEF_LSB +: fprc_pkg::COEF_W];

    assign rdy3 = !r_o_valid || i_m_tready;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;

    assign o_s_tready = rdy1;
    assign s_accept   = i_s_tvalid && rdy1;
    assign s_test     = (s_func == fprc_pkg::FUNC_POINT) || (s_func == fprc_pkg::FUNC_CORNER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int c = 0; c < fprc_pkg::NUM_COEFS; c++) begin
                    r_coef[p][c] <= '0;
                end
            end
        end else if (s_accept && s_func == fprc_pkg::FUNC_LOAD) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int c = 0; c < fprc_pkg::NUM_COEFS; c++) begin
                    if (s_psel == fprc_pkg::PSEL_W'(p) && s_csel == fprc_pkg::CSEL_W'(c)) begin
                        r_coef[p][c] <= s_coef;
                    end
                end
            end
        end
    end

    // Input register: keep only words that produce a test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (rdy1) begin
            r1_valid <= i_s_tvalid && s_test;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_rect <= (s_func == fprc_pkg::FUNC_CORNER);
            r1_last <= i_s_tlast;
            r1_x    <= i_s_tdata[fprc_pkg::X_LSB +: fprc_pkg::POS_W];
            r1_y    <= i_s_tdata[fprc_pkg::Y_LSB +: fprc_pkg::POS_W];
            r1_z    <= i_s_tdata[fprc_pkg::Z_LSB +: fprc_pkg::POS_W];
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            n_prod[p][fprc_pkg::COEF_A] = r_coef[p][fprc_pkg::COEF_A] * r1_x;
            n_prod[p][fprc_pkg::COEF_B] = r_coef[p][fprc_pkg::COEF_B] * r1_y;
            n_prod[p][fprc_pkg::COEF_C] = r_coef[p][fprc_pkg::COEF_C] * r1_z;
            n_prod[p][fprc_pkg::COEF_D] =
                fprc_pkg::PROD_W'(r_coef[p][fprc_pkg::COEF_D]) <<< fprc_pkg::D_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (rdy2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_rect <= r1_rect;
            r2_last <= r1_last;
            r2_prod <= n_prod;
        end
    end

    // Exact sign of the four-term sum per plane.
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            plane_sum[p] = fprc_pkg::SUM_W'(r2_prod[p][fprc_pkg::COEF_A])
                         + fprc_pkg::SUM_W'(r2_prod[p][fprc_pkg::COEF_B])
                         + fprc_pkg::SUM_W'(r2_prod[p][fprc_pkg::COEF_C])
                         + fprc_pkg::SUM_W'(r2_prod[p][fprc_pkg::COEF_D]);
            ahead[p] = !plane_sum[p][fprc_pkg::SUM_W-1] && (plane_sum[p] != '0);
        end
        n_seen = r_seen | ahead;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_seen    <= '0;
        end else if (rdy3) begin
            r_o_valid <= r2_valid && (!r2_rect || r2_last);
            if (r2_valid && r2_rect) begin
                r_seen <= r2_last ? '0 : n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_o_rect   <= r2_rect;
            r_o_inside <= r2_rect ? (n_seen == FULL_MASK) : (ahead == FULL_MASK);
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(fprc_pkg::M_TDATA_W-1){1'b0}}, r_o_inside};
    assign o_m_tuser  = r_o_rect;

endmodule
